/* hw/rtl/assert_macros.svh */
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/qts_pkg.sv */
// shared constants, types and arithmetic helpers of the quintic trajectory sampler
package qts_pkg;

    localparam int SEGMENTS     = 64;
    localparam int AXES         = 3;
    localparam int POWERS       = 6;
    localparam int SEG_AW       = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int COEFF_DEPTH  = SEGMENTS * AXES * POWERS;
    localparam int CF_AW        = $clog2(COEFF_DEPTH);
    localparam int CNT_W        = 7;
    localparam int COEF_W       = 48;
    localparam int TS_W         = 24;
    localparam int FACT_W       = 5;
    localparam int TERM_W       = COEF_W + FACT_W + 1;
    localparam int PROD_W       = COEF_W + TS_W;
    localparam int SUM_W        = 64;
    localparam int OUT_W        = 32;
    localparam int HDG_W        = 16;
    localparam int VAL_N        = AXES * 3;
    localparam int VAL_AW       = $clog2(VAL_N);
    localparam int MUL_CW       = $clog2(TS_W + 1);
    localparam int TIME_FRAC    = 10;
    localparam int CORDIC_W     = 36;
    localparam int CORDIC_STEPS = 24;
    localparam int CSTEP_W      = $clog2(CORDIC_STEPS);
    localparam int ANGLE_W      = 32;

    localparam logic [SUM_W-1:0]   SPEED_SQ_MIN = SUM_W'(42949672);
    localparam logic [ANGLE_W-1:0] ANGLE_HALF   = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] ANGLE_ROUND  = 32'h0000_8000;

    localparam logic REG_SEG_COUNT = 1'b0;

    typedef enum logic [1:0] {
        MODE_COEF   = 2'd0,
        MODE_DUR    = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // clamp to the signed 48-bit range
    function automatic logic signed [COEF_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sh0000_7FFF_FFFF_FFFF);
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            sat48 = COEF_W'(hi);
        end else if (v < lo) begin
            sat48 = COEF_W'(lo);
        end else begin
            sat48 = COEF_W'(v);
        end
    endfunction

    // Q16.32 accumulator to Q16.16 with round half up and 32-bit saturation
    function automatic logic signed [OUT_W-1:0] round_q16(input logic signed [COEF_W-1:0] acc);
        logic signed [COEF_W:0]   rnd;
        logic signed [COEF_W-16:0] shr;
        rnd = (COEF_W+1)'(acc) + (COEF_W+1)'(32768);
        shr = (COEF_W-15)'(rnd >>> 16);
        if (shr > (COEF_W-15)'(33'sh0_7FFF_FFFF)) begin
            round_q16 = 32'sh7FFF_FFFF;
        end else if (shr < (COEF_W-15)'(-33'sh0_8000_0000)) begin
            round_q16 = 32'sh8000_0000;
        end else begin
            round_q16 = OUT_W'(shr);
        end
    endfunction

    // derivative factor of power j for derivative order p
    function automatic logic [FACT_W-1:0] horner_factor(input logic [1:0] p, input logic [2:0] j);
        logic [FACT_W-1:0] f;
        f = '0;
        case ({p, j})
            {2'd0, 3'd0}, {2'd0, 3'd1}, {2'd0, 3'd2},
            {2'd0, 3'd3}, {2'd0, 3'd4}, {2'd0, 3'd5}: f = 5'd1;
            {2'd1, 3'd1}: f = 5'd1;
            {2'd1, 3'd2}: f = 5'd2;
            {2'd1, 3'd3}: f = 5'd3;
            {2'd1, 3'd4}: f = 5'd4;
            {2'd1, 3'd5}: f = 5'd5;
            {2'd2, 3'd2}: f = 5'd2;
            {2'd2, 3'd3}: f = 5'd6;
            {2'd2, 3'd4}: f = 5'd12;
            {2'd2, 3'd5}: f = 5'd20;
            default: f = '0;
        endcase
        return f;
    endfunction

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [ANGLE_W-1:0] atan_step(input logic [CSTEP_W-1:0] i);
        logic [ANGLE_W-1:0] a;
        a = '0;
        case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hw/rtl/qts_serial_mul.sv */
// bit-serial signed by unsigned multiplier, one bit of the time operand per cycle
module qts_serial_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [qts_pkg::COEF_W-1:0]    i_a,
    input  logic        [qts_pkg::TS_W-1:0]      i_b,
    output logic                                 o_done,
    output logic signed [qts_pkg::PROD_W-1:0]    o_prod
);

    logic signed [qts_pkg::PROD_W-1:0] r_mcand;
    logic signed [qts_pkg::PROD_W-1:0] r_prod;
    logic        [qts_pkg::TS_W-1:0]   r_mplier;
    logic        [qts_pkg::MUL_CW-1:0] r_cnt;
    logic                              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= qts_pkg::MUL_CW'(qts_pkg::TS_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - qts_pkg::MUL_CW'(1);
                if (r_cnt == qts_pkg::MUL_CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= qts_pkg::PROD_W'(i_a);
            r_mplier <= i_b;
            r_prod   <= '0;
        end else if (r_cnt != '0) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* hw/rtl/qts_cordic.sv */
// iterative vectoring cordic giving the heading of a planar velocity
module qts_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [qts_pkg::OUT_W-1:0]  i_x,
    input  logic signed [qts_pkg::OUT_W-1:0]  i_y,
    output logic                              o_done,
    output logic        [qts_pkg::HDG_W-1:0]  o_heading
);

    logic signed [qts_pkg::CORDIC_W-1:0] r_x;
    logic signed [qts_pkg::CORDIC_W-1:0] r_y;
    logic        [qts_pkg::ANGLE_W-1:0]  r_z;
    logic        [qts_pkg::CSTEP_W-1:0]  r_step;
    logic                                r_busy;
    logic                                r_done;

    logic signed [qts_pkg::CORDIC_W-1:0] x_ext;
    logic signed [qts_pkg::CORDIC_W-1:0] y_ext;
    logic signed [qts_pkg::CORDIC_W-1:0] xs;
    logic signed [qts_pkg::CORDIC_W-1:0] ys;
    logic        [qts_pkg::ANGLE_W-1:0]  z_rnd;

    always_comb begin
        x_ext     = qts_pkg::CORDIC_W'(i_x);
        y_ext     = qts_pkg::CORDIC_W'(i_y);
        xs        = r_x >>> r_step;
        ys        = r_y >>> r_step;
        z_rnd     = r_z + qts_pkg::ANGLE_ROUND;
        o_heading = z_rnd[qts_pkg::ANGLE_W-1 -: qts_pkg::HDG_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + qts_pkg::CSTEP_W'(1);
                if (r_step == qts_pkg::CSTEP_W'(qts_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // left half plane: rotate by pi first
            if (i_x < 0) begin
                r_x <= -x_ext;
                r_y <= -y_ext;
                r_z <= qts_pkg::ANGLE_HALF;
            end else begin
                r_x <= x_ext;
                r_y <= y_ext;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + qts_pkg::atan_step(r_step);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - qts_pkg::atan_step(r_step);
            end
        end
    end

    assign o_done = r_done;

endmodule

/* hw/rtl/quintic_trajectory_sampler_unit.sv */
// quintic trajectory sampler: segment store, segment search, serial horner and heading
//
// Input channel (i_valid / o_stall) takes one transaction per item. Mode 0 writes one
// coefficient and is done in its accept cycle. Mode 1 writes a segment duration and the
// cumulative end time through LD_RD and LD_WR. Mode 2 samples at i_elapsed_time; mode 3
// is dropped. A sample runs the segment search, which reads one end time at a time, then
// 36 horner steps, each through the bit-serial multiplier at one time bit per cycle.
// The heading cordic runs only when the planar speed exceeds 0.1.
// While segment_count is zero a sample gives no result and is dropped at once.
// Output channel (o_valid / i_stall) holds each result in an output register until it
// is taken; a new item is accepted while a result still waits, and a finished sample
// waits in its last state while the receiver stalls.
// segment_count is written over the APB port at byte address 0.
// Reset clears control state, segment_count, the held heading and the completion mark;
// the coefficient and time stores are not cleared and must be loaded before use.
module quintic_trajectory_sampler_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_mode,
    input  logic [5:0]                         i_segment,
    input  logic [1:0]                         i_axis,
    input  logic [2:0]                         i_coeff_index,
    input  logic signed [47:0]                 i_coefficient,
    input  logic [23:0]                        i_duration,
    input  logic [23:0]                        i_elapsed_time,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [31:0]                 o_pos_x,
    output logic signed [31:0]                 o_pos_y,
    output logic signed [31:0]                 o_pos_z,
    output logic signed [31:0]                 o_vel_x,
    output logic signed [31:0]                 o_vel_y,
    output logic signed [31:0]                 o_vel_z,
    output logic signed [31:0]                 o_acc_x,
    output logic signed [31:0]                 o_acc_y,
    output logic signed [31:0]                 o_acc_z,
    output logic signed [15:0]                 o_heading,
    output logic                               o_complete
);

    typedef enum logic [20:0] {
        ST_IDLE      = 21'h000001,
        ST_LD_RD     = 21'h000002,
        ST_LD_WR     = 21'h000004,
        ST_TOT_RD    = 21'h000008,
        ST_TOT_CHK   = 21'h000010,
        ST_SRCH_RD   = 21'h000020,
        ST_SRCH_CHK  = 21'h000040,
        ST_START_RD  = 21'h000080,
        ST_START_CHK = 21'h000100,
        ST_DUR_RD    = 21'h000200,
        ST_TS        = 21'h000400,
        ST_CF_RD     = 21'h000800,
        ST_TERM      = 21'h001000,
        ST_MUL       = 21'h002000,
        ST_FIN       = 21'h004000,
        ST_SQX       = 21'h008000,
        ST_SQY       = 21'h010000,
        ST_SQ_CHK    = 21'h020000,
        ST_CORDIC    = 21'h040000,
        ST_OUT       = 21'h080000,
        ST_WAIT      = 21'h100000
    } t_state;

    localparam int SA = qts_pkg::SEG_AW;
    localparam int TW = qts_pkg::TS_W;

    t_state r_state;
    t_state n_state;

    // stores
    logic signed [qts_pkg::COEF_W-1:0] r_coeff_mem [qts_pkg::COEFF_DEPTH];
    logic        [TW-1:0]              r_dur_mem   [qts_pkg::SEGMENTS];
    logic        [TW-1:0]              r_end_mem   [qts_pkg::SEGMENTS];
    logic signed [qts_pkg::COEF_W-1:0] r_coeff_rd;
    logic        [TW-1:0]              r_dur_rd;
    logic        [TW-1:0]              r_end_rd;

    logic [qts_pkg::CNT_W-1:0]  r_seg_count;
    logic [qts_pkg::CNT_W-1:0]  r_n;
    logic [TW-1:0]              r_t;
    logic                       r_finished;
    logic                       r_fin_mark;
    logic [qts_pkg::CNT_W-1:0]  r_i;
    logic [TW-1:0]              r_prev;
    logic [SA-1:0]              r_idx;
    logic [TW-1:0]              r_start;
    logic [TW-1:0]              r_ts;
    logic [1:0]                 r_axis;
    logic [1:0]                 r_poly;
    logic [2:0]                 r_j;
    logic signed [qts_pkg::TERM_W-1:0] r_term;
    logic signed [qts_pkg::COEF_W-1:0] r_acc;
    logic signed [qts_pkg::OUT_W-1:0]  r_val [qts_pkg::VAL_N];
    logic [qts_pkg::SUM_W-1:0]  r_sqa;
    logic [qts_pkg::SUM_W-1:0]  r_sqb;
    logic [qts_pkg::HDG_W-1:0]  r_held_heading;
    logic [SA-1:0]              r_ld_seg;
    logic [TW-1:0]              r_ld_dur;

    logic                              r_out_valid;
    logic signed [qts_pkg::OUT_W-1:0]  r_out_val [qts_pkg::VAL_N];
    logic [qts_pkg::HDG_W-1:0]         r_out_heading;
    logic                              r_out_complete;

    // combinational helpers
    logic                              accept;
    logic                              out_take;
    logic                              out_free;
    logic                              seg_ok;
    logic [qts_pkg::CNT_W-1:0]         n_eff;
    logic [SA-1:0]                     end_ra;
    logic [qts_pkg::CF_AW-1:0]         coeff_ra;
    logic [qts_pkg::CF_AW-1:0]         coeff_wa;
    logic signed [qts_pkg::TERM_W-1:0] term;
    logic signed [qts_pkg::PROD_W-1:0] prod_sh;
    logic signed [qts_pkg::SUM_W-1:0]  horner_sum;
    logic [TW:0]                       end_sum;
    logic [TW-1:0]                     end_prev;
    logic [TW-1:0]                     ts_raw;
    logic signed [qts_pkg::OUT_W-1:0]  sq_op;
    logic signed [qts_pkg::SUM_W-1:0]  sq_prod;
    logic [qts_pkg::VAL_AW-1:0]        val_wa;
    logic                              cfg_wr;

    logic                              mul_start;
    logic                              mul_done;
    logic signed [qts_pkg::PROD_W-1:0] mul_prod;
    logic                              cor_start;
    logic                              cor_done;
    logic [qts_pkg::HDG_W-1:0]         cor_heading;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign seg_ok   = int'(i_segment) < qts_pkg::SEGMENTS;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == qts_pkg::REG_SEG_COUNT);

    always_comb begin
        if (int'(r_seg_count) > qts_pkg::SEGMENTS) begin
            n_eff = qts_pkg::CNT_W'(qts_pkg::SEGMENTS);
        end else begin
            n_eff = r_seg_count;
        end
    end

    always_comb begin
        case (r_state)
            ST_LD_RD:    end_ra = r_ld_seg - SA'(1);
            ST_TOT_RD:   end_ra = SA'(r_n - qts_pkg::CNT_W'(1));
            ST_START_RD: end_ra = SA'(r_n - qts_pkg::CNT_W'(2));
            default:     end_ra = SA'(r_i);
        endcase
    end

    always_comb begin
        coeff_ra = qts_pkg::CF_AW'(int'(r_idx) * (qts_pkg::AXES * qts_pkg::POWERS)
                                   + int'(r_axis) * qts_pkg::POWERS + int'(r_j));
        coeff_wa = qts_pkg::CF_AW'(int'(i_segment) * (qts_pkg::AXES * qts_pkg::POWERS)
                                   + int'(i_axis) * qts_pkg::POWERS + int'(i_coeff_index));
        term       = r_coeff_rd * $signed({1'b0, qts_pkg::horner_factor(r_poly, r_j)});
        prod_sh    = mul_prod >>> qts_pkg::TIME_FRAC;
        horner_sum = qts_pkg::SUM_W'(prod_sh) + qts_pkg::SUM_W'(r_term);
        end_prev   = (r_ld_seg == '0) ? '0 : r_end_rd;
        end_sum    = {1'b0, end_prev} + {1'b0, r_ld_dur};
        ts_raw     = (r_t > r_start) ? (r_t - r_start) : '0;
        sq_op      = (r_state == ST_SQX) ? r_val[1] : r_val[4];
        sq_prod    = sq_op * sq_op;
        val_wa     = qts_pkg::VAL_AW'(int'(r_axis) * 3 + int'(r_poly));
        mul_start  = (r_state == ST_TERM) && (r_j != 3'(qts_pkg::POWERS - 1));
        cor_start  = (r_state == ST_SQ_CHK) && ((r_sqa + r_sqb) > qts_pkg::SPEED_SQ_MIN);
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (accept && i_mode == qts_pkg::MODE_COEF && seg_ok && i_axis < 2'(qts_pkg::AXES)
            && i_coeff_index < 3'(qts_pkg::POWERS)) begin
            r_coeff_mem[coeff_wa] <= i_coefficient;
        end
        r_coeff_rd <= r_coeff_mem[coeff_ra];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_mode == qts_pkg::MODE_DUR && seg_ok) begin
            r_dur_mem[SA'(i_segment)] <= i_duration;
        end
        r_dur_rd <= r_dur_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LD_WR) begin
            r_end_mem[r_ld_seg] <= end_sum[TW] ? {TW{1'b1}} : end_sum[TW-1:0];
        end
        r_end_rd <= r_end_mem[end_ra];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_mode == qts_pkg::MODE_DUR && seg_ok) begin
                        n_state = ST_LD_RD;
                    end else if (i_mode == qts_pkg::MODE_SAMPLE && n_eff != '0) begin
                        n_state = ST_TOT_RD;
                    end
                end
            end
            ST_LD_RD:     n_state = ST_LD_WR;
            ST_LD_WR:     n_state = ST_IDLE;
            ST_TOT_RD:    n_state = ST_TOT_CHK;
            ST_TOT_CHK: begin
                if (r_t >= r_end_rd) begin
                    n_state = (r_n == qts_pkg::CNT_W'(1)) ? ST_DUR_RD : ST_START_RD;
                end else begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:   n_state = ST_SRCH_CHK;
            ST_SRCH_CHK: begin
                if ((r_t >= r_prev && r_t < r_end_rd) || r_i == r_n - qts_pkg::CNT_W'(1)) begin
                    n_state = ST_DUR_RD;
                end else begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_START_RD:  n_state = ST_START_CHK;
            ST_START_CHK: n_state = ST_DUR_RD;
            ST_DUR_RD:    n_state = ST_TS;
            ST_TS:        n_state = ST_CF_RD;
            ST_CF_RD:     n_state = ST_TERM;
            ST_TERM:      n_state = mul_start ? ST_MUL : ST_CF_RD;
            ST_MUL: begin
                if (mul_done) begin
                    n_state = (r_j == {1'b0, r_poly}) ? ST_FIN : ST_CF_RD;
                end
            end
            ST_FIN: begin
                if (r_poly == 2'd2 && r_axis == 2'(qts_pkg::AXES - 1)) begin
                    n_state = ST_SQX;
                end else begin
                    n_state = ST_CF_RD;
                end
            end
            ST_SQX:       n_state = ST_SQY;
            ST_SQY:       n_state = ST_SQ_CHK;
            ST_SQ_CHK:    n_state = cor_start ? ST_CORDIC : ST_OUT;
            ST_CORDIC:    n_state = cor_done ? ST_OUT : ST_CORDIC;
            ST_OUT:       n_state = out_free ? ST_IDLE : ST_WAIT;
            ST_WAIT:      n_state = out_free ? ST_IDLE : ST_WAIT;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_seg_count    <= '0;
            r_held_heading <= '0;
            r_fin_mark     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_seg_count <= pwdata[qts_pkg::CNT_W-1:0];
            end
            if (accept && (i_mode == qts_pkg::MODE_COEF || i_mode == qts_pkg::MODE_DUR)) begin
                r_fin_mark <= 1'b0;
            end
            if (r_state == ST_CORDIC && cor_done) begin
                r_held_heading <= cor_heading;
            end
            if ((r_state == ST_OUT || r_state == ST_WAIT) && out_free) begin
                r_out_valid <= 1'b1;
                r_fin_mark  <= r_fin_mark | r_finished;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ld_seg   <= SA'(i_segment);
                r_ld_dur   <= i_duration;
                r_t        <= i_elapsed_time;
                r_n        <= n_eff;
                r_finished <= 1'b0;
            end
            ST_TOT_CHK: begin
                r_i    <= '0;
                r_prev <= '0;
                // at or past the total time: clamp to the last segment
                if (r_t >= r_end_rd) begin
                    r_t        <= r_end_rd;
                    r_finished <= 1'b1;
                    r_idx      <= SA'(r_n - qts_pkg::CNT_W'(1));
                    r_start    <= '0;
                end
            end
            ST_SRCH_CHK: begin
                if (r_t >= r_prev && r_t < r_end_rd) begin
                    r_idx   <= SA'(r_i);
                    r_start <= r_prev;
                end else if (r_i == r_n - qts_pkg::CNT_W'(1)) begin
                    r_idx   <= '0;
                    r_start <= '0;
                end else begin
                    r_prev <= r_end_rd;
                    r_i    <= r_i + qts_pkg::CNT_W'(1);
                end
            end
            ST_START_CHK: begin
                r_start <= r_end_rd;
            end
            ST_TS: begin
                r_ts   <= (ts_raw > r_dur_rd) ? r_dur_rd : ts_raw;
                r_axis <= '0;
                r_poly <= '0;
                r_j    <= 3'(qts_pkg::POWERS - 1);
            end
            ST_TERM: begin
                r_term <= term;
                if (!mul_start) begin
                    r_acc <= qts_pkg::sat48(qts_pkg::SUM_W'(term));
                    r_j   <= r_j - 3'd1;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    r_acc <= qts_pkg::sat48(horner_sum);
                    if (r_j != {1'b0, r_poly}) begin
                        r_j <= r_j - 3'd1;
                    end
                end
            end
            ST_FIN: begin
                r_val[val_wa] <= qts_pkg::round_q16(r_acc);
                r_j <= 3'(qts_pkg::POWERS - 1);
                if (r_poly == 2'd2) begin
                    r_poly <= '0;
                    r_axis <= r_axis + 2'd1;
                end else begin
                    r_poly <= r_poly + 2'd1;
                end
            end
            ST_SQX: r_sqa <= qts_pkg::SUM_W'(sq_prod);
            ST_SQY: r_sqb <= qts_pkg::SUM_W'(sq_prod);
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT || r_state == ST_WAIT) && out_free) begin
            for (int k = 0; k < qts_pkg::VAL_N; k++) begin
                r_out_val[k] <= r_val[k];
            end
            r_out_heading  <= r_held_heading;
            r_out_complete <= r_finished && !r_fin_mark;
        end
    end

    qts_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_acc),
        .i_b     (r_ts),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    qts_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cor_start),
        .i_x       (r_val[1]),
        .i_y       (r_val[4]),
        .o_done    (cor_done),
        .o_heading (cor_heading)
    );

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == qts_pkg::REG_SEG_COUNT) ? 32'(r_seg_count) : '0;
    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_pos_x    = r_out_val[0];
    assign o_vel_x    = r_out_val[1];
    assign o_acc_x    = r_out_val[2];
    assign o_pos_y    = r_out_val[3];
    assign o_vel_y    = r_out_val[4];
    assign o_acc_y    = r_out_val[5];
    assign o_pos_z    = r_out_val[6];
    assign o_vel_z    = r_out_val[7];
    assign o_acc_z    = r_out_val[8];
    assign o_heading  = r_out_heading;
    assign o_complete = r_out_complete;

endmodule

/* hw/rtl/qts_checker.sv */
// port-level checker for the quintic trajectory sampler, bound to the top level
`include "assert_macros.svh"

module qts_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [1:0]         i_mode,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_pos_x,
    input logic signed [15:0] o_heading
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_pos_x) && $stable(o_heading))
    `ASSERT_IMPLIES(a_result_after_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))
    `ASSERT_NEXT(a_coef_load_single, i_clk, i_rst_n, i_valid && !o_stall && i_mode == qts_pkg::MODE_COEF, !o_stall)

endmodule

bind quintic_trajectory_sampler_unit qts_checker u_qts_checker (.*);

/* sim/quintic_trajectory_sampler_unit_tb.sv */
// testbench of the quintic trajectory sampler: transactions checked against a local predictor
module quintic_trajectory_sampler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] motion[9];
        logic [15:0]        heading;
        logic               complete;
    } t_setpoint;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_mode;
    logic [5:0]         i_segment;
    logic [1:0]         i_axis;
    logic [2:0]         i_coeff_index;
    logic signed [47:0] i_coefficient;
    logic [23:0]        i_duration;
    logic [23:0]        i_elapsed_time;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [31:0] o_vel_x, o_vel_y, o_vel_z;
    logic signed [31:0] o_acc_x, o_acc_y, o_acc_z;
    logic signed [15:0] o_heading;
    logic               o_complete;

    quintic_trajectory_sampler_unit dut (.*);

    // local copy of the block state
    longint      coef_mem[qts_pkg::SEGMENTS*qts_pkg::AXES*qts_pkg::POWERS];
    logic [23:0] dur_mem[qts_pkg::SEGMENTS];
    logic [23:0] end_mem[qts_pkg::SEGMENTS];
    logic [15:0] held_hdg;
    logic        done_mark;
    logic [6:0]  seg_count;

    t_setpoint   pending_setpoints[$];
    int          errors;
    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          rx_hold;

    // segments whose coefficients are loaded, beside the last one
    localparam int LIVE_SEGS = 8;
    localparam longint Q48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q48_LO = -Q48_HI - 1;
    localparam logic [31:0] ATAN_TURNS[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    localparam string FIELD_NAMES[9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y",
        "vel_z", "acc_x", "acc_y", "acc_z"};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("** quintic_trajectory_sampler_unit: FAILED **");
        $finish;
    end

    function automatic longint clamp48(longint v);
        if (v > Q48_HI) return Q48_HI;
        if (v < Q48_LO) return Q48_LO;
        return v;
    endfunction

    // polynomial in Q16.32 with time in 1/1024 s, rounded to Q16.16
    function automatic longint eval_poly(longint terms[6], int n, longint ts);
        longint acc;
        longint r;
        acc = clamp48(terms[n-1]);
        for (int k = n - 2; k >= 0; k--)
            acc = clamp48(acc * (ts >> 12) * 4 + ((acc * (ts & 64'sd4095)) >>> 10)
                          + terms[k]);
        r = (acc + 32768) >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic logic [15:0] planar_heading(longint x, longint y);
        logic [31:0] z;
        longint xs, ys;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = qts_pkg::ANGLE_HALF;
        end
        for (int i = 0; i < qts_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        z = z + qts_pkg::ANGLE_ROUND;
        return z[31:16];
    endfunction

    // applies one accepted transaction to the local state, returns 1 with a setpoint
    function automatic bit predict_setpoint(qts_pkg::t_mode mode, int seg, int axis, int pw,
            logic signed [47:0] coef, logic [23:0] dur, logic [23:0] t_in,
            output t_setpoint sp);
        int n, idx;
        logic [24:0] e;
        logic [23:0] t, start, ts;
        bit finished;
        longint c[6], pt[6], vt[6], at[6];
        longint unsigned sq;
        finished = 0;
        idx = 0;
        if (mode == qts_pkg::MODE_COEF || mode == qts_pkg::MODE_DUR) begin
            done_mark = 1'b0;
            if (mode == qts_pkg::MODE_COEF) begin
                if (axis < qts_pkg::AXES && pw < qts_pkg::POWERS)
                    coef_mem[(seg * qts_pkg::AXES + axis) * qts_pkg::POWERS + pw] =
                        longint'(coef);
            end else begin
                e = {1'b0, (seg != 0) ? end_mem[seg-1] : 24'd0} + {1'b0, dur};
                dur_mem[seg] = dur;
                end_mem[seg] = e[24] ? 24'hFF_FFFF : e[23:0];
            end
            return 0;
        end
        if (mode != qts_pkg::MODE_SAMPLE) return 0;
        n = (seg_count > qts_pkg::SEGMENTS) ? qts_pkg::SEGMENTS : seg_count;
        if (n == 0) return 0;
        t = t_in;
        if (t >= end_mem[n-1]) begin
            idx = n - 1;
            t = end_mem[n-1];
            finished = 1;
        end else begin
            for (int i = 0; i < n; i++) begin
                start = (i != 0) ? end_mem[i-1] : 24'd0;
                if (t >= start && t < end_mem[i]) begin
                    idx = i;
                    break;
                end
            end
        end
        start = (idx != 0) ? end_mem[idx-1] : 24'd0;
        ts = (t > start) ? t - start : 24'd0;
        if (ts > dur_mem[idx]) ts = dur_mem[idx];
        for (int a = 0; a < qts_pkg::AXES; a++) begin
            for (int k = 0; k < qts_pkg::POWERS; k++)
                c[k] = coef_mem[(idx * qts_pkg::AXES + a) * qts_pkg::POWERS + k];
            pt = c;
            vt = '{c[1], 2 * c[2], 3 * c[3], 4 * c[4], 5 * c[5], 0};
            at = '{2 * c[2], 6 * c[3], 12 * c[4], 20 * c[5], 0, 0};
            sp.motion[a]     = 32'(eval_poly(pt, 6, longint'(ts)));
            sp.motion[3 + a] = 32'(eval_poly(vt, 5, longint'(ts)));
            sp.motion[6 + a] = 32'(eval_poly(at, 4, longint'(ts)));
        end
        sq = longint'(sp.motion[3]) * longint'(sp.motion[3])
           + longint'(sp.motion[4]) * longint'(sp.motion[4]);
        if (sq > qts_pkg::SPEED_SQ_MIN)
            held_hdg = planar_heading(longint'(sp.motion[3]), longint'(sp.motion[4]));
        sp.heading = held_hdg;
        sp.complete = finished && !done_mark;
        if (sp.complete) done_mark = 1'b1;
        return 1;
    endfunction

    // result side: check each result taken against the next expected setpoint, then choose the next stall
    always @(posedge i_clk) begin
        t_setpoint exp_sp;
        logic signed [31:0] got[9];
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z,
                    o_acc_x, o_acc_y, o_acc_z};
            if (pending_setpoints.size() == 0) begin
                $error("setpoint with none expected");
                errors++;
            end else begin
                exp_sp = pending_setpoints.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== exp_sp.motion[i]) begin
                        $error("%s: expected %0d, got %0d", FIELD_NAMES[i],
                               exp_sp.motion[i], got[i]);
                        errors++;
                    end
                if (o_heading !== exp_sp.heading) begin
                    $error("heading: expected %0d, got %0d", $signed(exp_sp.heading), o_heading);
                    errors++;
                end
                if (o_complete !== exp_sp.complete) begin
                    $error("complete: expected %0d, got %0d", exp_sp.complete, o_complete);
                    errors++;
                end
            end
        end
        i_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
    end

    task automatic send_item(qts_pkg::t_mode mode, int seg, int axis, int pw,
            logic signed [47:0] coef, logic [23:0] dur, logic [23:0] t_in);
        t_setpoint sp;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_segment      <= 6'(seg);
        i_axis         <= 2'(axis);
        i_coeff_index  <= 3'(pw);
        i_coefficient  <= coef;
        i_duration     <= dur;
        i_elapsed_time <= t_in;
        do @(posedge i_clk); while (o_stall);
        if (predict_setpoint(mode, seg, axis, pw, coef, dur, t_in, sp))
            pending_setpoints.insert(pending_setpoints.size(), sp);
    endtask

    task automatic load_coef(int seg, int axis, int pw, logic signed [47:0] coef);
        send_item(qts_pkg::MODE_COEF, seg, axis, pw, coef, 24'($urandom), 24'($urandom));
    endtask

    task automatic load_duration(int seg, logic [23:0] dur);
        send_item(qts_pkg::MODE_DUR, seg, $urandom_range(3), $urandom_range(7),
                  48'($urandom), dur, 24'($urandom));
    endtask

    task automatic sample_at(logic [23:0] t_in);
        send_item(qts_pkg::MODE_SAMPLE, $urandom_range(63), $urandom_range(3),
                  $urandom_range(7), 48'($urandom), 24'($urandom), t_in);
    endtask

    // random coefficient, mostly scaled down so that most samples stay in range
    function automatic logic signed [47:0] rand_coef();
        logic signed [47:0] c;
        c = {16'($urandom), 32'($urandom)};
        case ($urandom_range(3))
            0: return c;
            1: return c >>> 12;
            default: return c >>> ($urandom_range(16, 30));
        endcase
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_setpoints.size() != 0) @(posedge i_clk);
        // wait on after the last expected setpoint has been taken
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic write_seg_count(logic [6:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'd0;
        pwdata  <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        seg_count = value;
    endtask

    function automatic logic [23:0] total_time();
        int n;
        n = (seg_count > qts_pkg::SEGMENTS) ? qts_pkg::SEGMENTS : seg_count;
        return (n == 0) ? 24'd0 : end_mem[n-1];
    endfunction

    // every duration in ascending segment order, coefficients of the segments samples reach
    task automatic test_full_load();
        for (int s = 0; s < qts_pkg::SEGMENTS; s++) begin
            if (s < LIVE_SEGS || s == qts_pkg::SEGMENTS - 1)
                for (int a = 0; a < qts_pkg::AXES; a++)
                    for (int k = 0; k < qts_pkg::POWERS; k++) load_coef(s, a, k, rand_coef());
            load_duration(s, 24'($urandom_range(1, 300)));
        end
        drain();
    endtask

    task automatic test_no_trajectory();
        write_seg_count(7'd0);
        sample_at(24'd0);
        sample_at(24'hFF_FFFF);
        send_item(qts_pkg::MODE_NONE, 0, 0, 0, '0, '0, '0);
        drain();
    endtask

    task automatic test_directed();
        logic [23:0] tot;
        write_seg_count(7'd4);
        tot = total_time();
        sample_at(24'd0);
        sample_at(end_mem[0]);
        sample_at(end_mem[1] - 1);
        sample_at(tot);
        sample_at(tot + 1);
        load_coef(2, 3, 0, 48'sd5);
        load_coef(2, 0, 6, 48'sd5);
        load_coef(2, 1, 7, -48'sd5);
        sample_at(24'hFF_FFFF);
        send_item(qts_pkg::MODE_NONE, 1, 1, 1, '1, '1, '1);
        // extreme coefficients on axes 0 and 1 drive the horner steps into saturation
        for (int k = 0; k < qts_pkg::POWERS; k++) begin
            load_coef(0, 0, k, 48'sh7FFF_FFFF_FFFF);
            load_coef(0, 1, k, 48'sh8000_0000_0000);
        end
        sample_at(24'd1);
        // stopped axes keep the last heading
        for (int k = 1; k < qts_pkg::POWERS; k++) begin
            load_coef(1, 0, k, '0);
            load_coef(1, 1, k, '0);
        end
        sample_at(end_mem[0] + 1);
        load_duration(2, 24'd0);
        load_duration(3, 24'hFF_FFFF);
        sample_at(24'hFF_FFFE);
        sample_at(end_mem[1]);
        drain();
    endtask

    task automatic test_count_extremes();
        write_seg_count(7'd64);
        sample_at(end_mem[0] - 1);
        sample_at(24'hFF_FFFF);
        drain();
        write_seg_count(7'd127);
        sample_at(24'd0);
        sample_at(24'hFF_FFFF);
        drain();
        write_seg_count(7'd1);
        sample_at(24'd0);
        sample_at(24'hFF_FFFF);
        drain();
    endtask

    // random mix, loads aimed mostly at segments in use
    task automatic test_random_phase(int tx_pct, int rx_pct, int items);
        int n, seg, r;
        logic [23:0] tot;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        write_seg_count(7'($urandom_range(1, LIVE_SEGS)));
        n = (seg_count > qts_pkg::SEGMENTS) ? qts_pkg::SEGMENTS : seg_count;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            seg = ($urandom_range(9) < 8) ? $urandom_range(n - 1) : $urandom_range(63);
            tot = total_time();
            if (r < 40) begin
                if ($urandom_range(4) != 0)
                    sample_at(24'($urandom_range(0, tot + tot / 8 + 1)));
                else
                    sample_at(24'($urandom));
            end else if (r < 75) begin
                if ($urandom_range(19) == 0)
                    load_coef(seg, $urandom_range(3), $urandom_range(7), rand_coef());
                else
                    load_coef(seg, $urandom_range(2), $urandom_range(5), rand_coef());
            end else if (r < 95) begin
                load_duration(seg, ($urandom_range(19) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(1, 2000)));
            end else begin
                send_item(qts_pkg::MODE_NONE, $urandom_range(63), $urandom_range(3),
                          $urandom_range(7), {16'($urandom), 32'($urandom)},
                          24'($urandom), 24'($urandom));
            end
        end
        drain();
    endtask

    // the receiver holds off while samples keep coming, so the input backs up
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_seg_count(7'd2);
        fork
            begin
                rx_hold = 1'b1;
                repeat (6000) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 5; i++) sample_at(24'($urandom_range(0, total_time())));
            end
        join
        drain();
    endtask

    initial begin
        errors = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold = 1'b0;
        held_hdg = '0;
        done_mark = 1'b0;
        seg_count = '0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_mode <= qts_pkg::MODE_COEF;
        i_segment <= '0;
        i_axis <= '0;
        i_coeff_index <= '0;
        i_coefficient <= '0;
        i_duration <= '0;
        i_elapsed_time <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_load();
        test_no_trajectory();
        test_directed();
        test_count_extremes();
        test_random_phase(9, 58, 90);
        test_random_phase(58, 9, 90);
        test_random_phase(0, 0, 90);
        test_backpressure();

        if (errors == 0)
            $display("** quintic_trajectory_sampler_unit: PASSED **");
        else
            $display("** quintic_trajectory_sampler_unit: FAILED **");
        $finish;
    end
endmodule
